// ===== hdl/sfr_pkg.sv =====
// Package for the serial frame receiver: widths, codes, parse phases and the
// result record shared by the interfaces, the parser and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int LENGTH_W     = 16;
    localparam int OFFSET_W     = 10;
    localparam int MAX_PAYLOAD  = 1016;
    // Payload byte counter only has to reach MAX_PAYLOAD
    localparam int COUNT_W      = $clog2(MAX_PAYLOAD + 1);

    // Configuration register map
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_HIGH = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LOW  = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BADSUM  = 2'd2,
        KIND_TOOLONG = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_HUNT_HIGH = 4'd0,
        PH_HUNT_LOW  = 4'd1,
        PH_COMMAND   = 4'd2,
        PH_LEN_HIGH  = 4'd3,
        PH_LEN_LOW   = 4'd4,
        PH_PAYLOAD   = 4'd5,
        PH_CHECKSUM  = 4'd6,
        PH_TRAILER_A = 4'd7,
        PH_TRAILER_B = 4'd8
    } phase_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    command;
        logic [BYTE_W-1:0]    pbyte;
        logic [OFFSET_W-1:0]  offset;
        logic [LENGTH_W-1:0]  length;
        logic                 done;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/sfr_rx_if.sv =====
// Byte input channel of the serial frame receiver (valid/ready).
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_rx_if
    import sfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfr_result_if.sv =====
// Result channel of the serial frame receiver (valid/ready).
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_result_if
    import sfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          result_kind;
    logic [BYTE_W-1:0]   frame_command;
    logic [BYTE_W-1:0]   payload_byte;
    logic [OFFSET_W-1:0] payload_offset;
    logic [LENGTH_W-1:0] frame_length;
    logic                frame_done;

    modport source (output valid, output result_kind, output frame_command,
                    output payload_byte, output payload_offset,
                    output frame_length, output frame_done, input ready);
    modport sink   (input valid, input result_kind, input frame_command,
                    input payload_byte, input payload_offset,
                    input frame_length, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfr_parser.sv =====
// Frame parse state machine: phase, held header fields, byte count and sum.
// Advances one byte per step and flags the result that byte causes.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] sync_high,
    input  wire logic [BYTE_W-1:0] sync_low,
    output logic                   res_valid,
    output result_t                res
);

    phase_t               phase_reg,   phase_next;
    logic [BYTE_W-1:0]    command_reg, command_next;
    logic [LENGTH_W-1:0]  length_reg,  length_next;
    logic [COUNT_W-1:0]   count_reg,   count_next;
    logic [BYTE_W-1:0]    sum_reg,     sum_next;
    kind_t                status_reg,  status_next;

    logic [BYTE_W-1:0]    sum_add;
    logic [COUNT_W:0]     count_inc;

    assign sum_add   = sum_reg + rx_byte;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT_HIGH;
            command_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            status_reg  <= KIND_PAYLOAD;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            status_reg  <= status_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;
        res_valid    = 1'b0;
        res.kind     = KIND_PAYLOAD;
        res.pbyte    = '0;
        res.offset   = '0;
        res.done     = 1'b0;

        case (phase_reg)
            PH_HUNT_LOW:
            begin
                if (rx_byte == sync_low)
                begin
                    sum_next   = sum_add;
                    phase_next = PH_COMMAND;
                end
                else if (rx_byte == sync_high)
                    sum_next = rx_byte;
                else
                    phase_next = PH_HUNT_HIGH;
            end
            PH_COMMAND:
            begin
                command_next = rx_byte;
                sum_next     = sum_add;
                phase_next   = PH_LEN_HIGH;
            end
            PH_LEN_HIGH:
            begin
                length_next = {rx_byte, {(LENGTH_W-BYTE_W){1'b0}}};
                sum_next    = sum_add;
                phase_next  = PH_LEN_LOW;
            end
            PH_LEN_LOW:
            begin
                length_next = {length_reg[LENGTH_W-1:BYTE_W], rx_byte};
                sum_next    = sum_add;
                count_next  = '0;
                if (length_next > LENGTH_W'(MAX_PAYLOAD))
                begin
                    status_next = KIND_TOOLONG;
                    phase_next  = PH_HUNT_HIGH;
                    res_valid   = 1'b1;
                    res.kind    = KIND_TOOLONG;
                    res.done    = 1'b1;
                end
                else if (length_next == '0)
                    phase_next = PH_CHECKSUM;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                res_valid  = 1'b1;
                res.kind   = KIND_PAYLOAD;
                res.pbyte  = rx_byte;
                res.offset = OFFSET_W'(count_reg);
                sum_next   = sum_add;
                count_next = count_inc[COUNT_W-1:0];
                if (LENGTH_W'(count_inc) >= length_reg)
                    phase_next = PH_CHECKSUM;
            end
            PH_CHECKSUM:
            begin
                status_next = (rx_byte == sum_reg) ? KIND_GOOD : KIND_BADSUM;
                phase_next  = PH_TRAILER_A;
            end
            PH_TRAILER_A:
                phase_next = PH_TRAILER_B;
            PH_TRAILER_B:
            begin
                phase_next = PH_HUNT_HIGH;
                res_valid  = 1'b1;
                res.kind   = status_reg;
                res.done   = 1'b1;
            end
            default:
            begin
                // Hunting, and any phase code with no meaning
                phase_next = PH_HUNT_HIGH;
                if (rx_byte == sync_high)
                begin
                    sum_next   = rx_byte;
                    phase_next = PH_HUNT_LOW;
                end
            end
        endcase

        // Header fields reported with the state this byte leaves behind
        res.command = command_next;
        res.length  = length_next;
    end

endmodule

`default_nettype wire

// ===== hdl/serial_frame_receiver.sv =====
// Serial frame receiver: hunts for two sync bytes, parses command, length,
// payload and checksum, and reports payload bytes and a frame status.
// A byte enters the input register on acceptance and any result it causes is
// loaded into the output register when the parser steps on it; a step waits
// while a result is held for a sink that is not ready. Throughput: one byte per clock otherwise.
// Reset (rst_n low, asynchronous): both pipeline stages empty, parser hunting,
// sync registers cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver
    import sfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    sfr_rx_if.sink                      rx,
    sfr_result_if.source                result
);

    // Configuration registers
    logic [BYTE_W-1:0] sync_high_reg;
    logic [BYTE_W-1:0] sync_low_reg;

    // Input stage: one received byte waiting for the parser
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Output stage: one result waiting for the sink
    logic              out_valid_reg;
    result_t           out_reg;

    logic              step;
    logic              res_valid;
    result_t           res;

    // Configuration writes; the user must issue these only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_high_reg <= '0;
            sync_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SYNC_HIGH: sync_high_reg <= wr_data[BYTE_W-1:0];
                REG_SYNC_LOW:  sync_low_reg  <= wr_data[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Advance the parser when a byte is staged and the output slot is free
    // or drains this cycle. The input register refills in the same cycle.
    assign step     = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    // Payload register: capture on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    sfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .sync_high (sync_high_reg),
        .sync_low  (sync_low_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: load a new result, or drop the old one once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= res_valid;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_reg <= res;
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_reg.kind;
    assign result.frame_command  = out_reg.command;
    assign result.payload_byte   = out_reg.pbyte;
    assign result.payload_offset = out_reg.offset;
    assign result.frame_length   = out_reg.length;
    assign result.frame_done     = out_reg.done;

endmodule

`default_nettype wire
